### sv/sst_pkg.sv
// shared types, constants and helpers for the dsdt sleep type scanner
package sst_pkg;

    // fixed table layout
    localparam logic [31:0] HEADER_BYTES = 32'd36;
    localparam logic [31:0] NAME_MIN_POS = HEADER_BYTES + 32'd3;
    localparam int unsigned TYPE_SHIFT   = 10;

    // aml encodings
    localparam logic [7:0]  NAME_OP      = 8'h08;
    localparam logic [7:0]  ROOT_CHAR    = 8'h5C;
    localparam logic [7:0]  PACKAGE_OP   = 8'h12;
    localparam logic [7:0]  BYTE_PREFIX  = 8'h0A;
    localparam logic [7:0]  PKGLEN_MASK  = 8'hC0;
    localparam logic [31:0] NAME_WORD    = 32'h5F53_355F;
    localparam logic [15:0] SLP_EN_BIT   = 16'h2000;

    localparam logic [7:0] SIG_BYTES [4] = '{8'h44, 8'h53, 8'h44, 8'h54};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_HDR  = 2'd1,
        ST_NO_NAME  = 2'd2,
        ST_PARSE    = 2'd3
    } t_status;

    typedef enum logic [10:0] {
        PH_SEARCH   = 11'b000_0000_0001,
        PH_PKG_OP   = 11'b000_0000_0010,
        PH_PKG_LEAD = 11'b000_0000_0100,
        PH_SKIP     = 11'b000_0000_1000,
        PH_VAL_A    = 11'b000_0001_0000,
        PH_DATA_A   = 11'b000_0010_0000,
        PH_VAL_B    = 11'b000_0100_0000,
        PH_DATA_B   = 11'b000_1000_0000,
        PH_FOUND    = 11'b001_0000_0000,
        PH_ERROR    = 11'b010_0000_0000,
        PH_DONE     = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } t_result;

    function automatic logic [15:0] make_word(input logic [7:0] t);
        logic [23:0] w;
        w = {16'b0, t} << TYPE_SHIFT;
        return w[15:0] | SLP_EN_BIT;
    endfunction

endpackage

### sv/sst_parser.sv
// per-byte header check, checksum and _S5_ package parser
module sst_parser
    import sst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_beat,
    input  logic        i_start_req,
    input  logic [7:0]  i_data_byte,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [31:0] r_pos,    n_pos,    s_pos;
    logic [31:0] r_len,    n_len,    s_len;
    logic [31:0] r_last,   n_last;
    logic [7:0]  r_sum,    n_sum,    s_sum;
    logic        r_sig_ok, n_sig_ok, s_sig_ok;
    logic [39:0] r_win,    n_win,    s_win;
    t_phase      r_phase,  n_phase,  s_phase;
    logic [2:0]  r_skip,   n_skip,   s_skip;
    logic [7:0]  r_ta,     n_ta,     s_ta;
    logic [7:0]  r_tb,     n_tb,     s_tb;

    always_comb begin
        logic [7:0] b;
        logic [7:0] prev1;
        logic [7:0] prev2;
        logic       fire;
        t_status    st;

        b     = i_data_byte;
        fire  = 1'b0;
        st    = ST_OK;

        // start clears everything but the last-byte position before the byte is taken
        s_pos    = i_start_req ? '0 : r_pos;
        s_len    = i_start_req ? '0 : r_len;
        s_sum    = i_start_req ? '0 : r_sum;
        s_sig_ok = i_start_req ? 1'b1 : r_sig_ok;
        s_win    = i_start_req ? '0 : r_win;
        s_phase  = i_start_req ? PH_SEARCH : r_phase;
        s_skip   = i_start_req ? '0 : r_skip;
        s_ta     = i_start_req ? '0 : r_ta;
        s_tb     = i_start_req ? '0 : r_tb;

        prev1 = s_win[31:24];
        prev2 = s_win[39:32];

        n_pos    = r_pos;
        n_len    = r_len;
        n_last   = r_last;
        n_sum    = r_sum;
        n_sig_ok = r_sig_ok;
        n_win    = r_win;
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_ta     = r_ta;
        n_tb     = r_tb;

        if (i_beat) begin
            n_pos    = s_pos;
            n_len    = s_len;
            n_sum    = s_sum;
            n_sig_ok = s_sig_ok;
            n_win    = s_win;
            n_phase  = s_phase;
            n_skip   = s_skip;
            n_ta     = s_ta;
            n_tb     = s_tb;

            if (s_phase != PH_DONE) begin
                n_win = {s_win[31:0], b};
                n_sum = s_sum + b;

                if (s_pos < 32'd4) begin
                    if (b != SIG_BYTES[s_pos[1:0]]) n_sig_ok = 1'b0;
                end else if (s_pos < 32'd8) begin
                    case (s_pos[1:0])
                        2'd0:    n_len[7:0]   = b;
                        2'd1:    n_len[15:8]  = b;
                        2'd2:    n_len[23:16] = b;
                        2'd3:    n_len[31:24] = b;
                        default: n_len        = s_len;
                    endcase
                end
                if (s_pos == 32'd7) n_last = n_len - 32'd1;

                if (s_pos >= HEADER_BYTES) begin
                    case (s_phase)
                        PH_SEARCH: begin
                            if (s_pos >= NAME_MIN_POS && {s_win[23:0], b} == NAME_WORD) begin
                                if (prev1 == NAME_OP || (prev1 == ROOT_CHAR && prev2 == NAME_OP))
                                    n_phase = PH_PKG_OP;
                                else
                                    n_phase = PH_ERROR;
                            end
                        end
                        PH_PKG_OP: n_phase = (b == PACKAGE_OP) ? PH_PKG_LEAD : PH_ERROR;
                        PH_PKG_LEAD: begin
                            n_skip  = {1'b0, b[7:6] & PKGLEN_MASK[7:6]} + 3'd1;
                            n_phase = PH_SKIP;
                        end
                        PH_SKIP: begin
                            if (s_skip != 3'd0) n_skip = s_skip - 3'd1;
                            if (n_skip == 3'd0) n_phase = PH_VAL_A;
                        end
                        PH_VAL_A: begin
                            if (b == BYTE_PREFIX) begin
                                n_phase = PH_DATA_A;
                            end else begin
                                n_ta    = b;
                                n_phase = PH_VAL_B;
                            end
                        end
                        PH_DATA_A: begin
                            n_ta    = b;
                            n_phase = PH_VAL_B;
                        end
                        PH_VAL_B: begin
                            if (b == BYTE_PREFIX) begin
                                n_phase = PH_DATA_B;
                            end else begin
                                n_tb    = b;
                                n_phase = PH_FOUND;
                            end
                        end
                        PH_DATA_B: begin
                            n_tb    = b;
                            n_phase = PH_FOUND;
                        end
                        default: n_phase = s_phase;
                    endcase
                end

                // end of table decision
                if (s_pos == 32'd7 && n_len < HEADER_BYTES) begin
                    fire = 1'b1;
                    st   = ST_BAD_HDR;
                end else if (s_pos > 32'd7 && s_pos == r_last) begin
                    fire = 1'b1;
                    if (!n_sig_ok || n_sum != 8'd0)
                        st = ST_BAD_HDR;
                    else if (n_phase == PH_FOUND)
                        st = ST_OK;
                    else if (n_phase == PH_SEARCH)
                        st = ST_NO_NAME;
                    else
                        st = ST_PARSE;
                end

                if (fire) n_phase = PH_DONE;
                else      n_pos   = s_pos + 32'd1;
            end
        end

        o_res_valid   = fire;
        o_res.status  = st;
        o_res.word_a  = (st == ST_OK) ? make_word(n_ta) : 16'd0;
        o_res.word_b  = (st == ST_OK) ? make_word(n_tb) : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_last   <= '0;
            r_sum    <= '0;
            r_sig_ok <= 1'b1;
            r_win    <= '0;
            r_phase  <= PH_SEARCH;
            r_skip   <= '0;
            r_ta     <= '0;
            r_tb     <= '0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_last   <= n_last;
            r_sum    <= n_sum;
            r_sig_ok <= n_sig_ok;
            r_win    <= n_win;
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_ta     <= n_ta;
            r_tb     <= n_tb;
        end
    end

endmodule

### sv/sst_out_buf.sv
// result register with one skid entry
module sst_out_buf
    import sst_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_ov;
    logic    r_sv;
    t_result r_o;
    t_result r_s;
    logic    pop;

    assign pop        = r_ov && i_ready;
    assign o_can_push = !r_sv;
    assign o_valid    = r_ov;
    assign o_data     = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (pop) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_ov <= i_push;
            end
        end else if (i_push) begin
            if (!r_ov) r_ov <= 1'b1;
            else       r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_sv)        r_o <= r_s;
            else if (i_push) r_o <= i_data;
        end else if (i_push) begin
            if (!r_ov) r_o <= i_data;
            else       r_s <= i_data;
        end
    end

endmodule

### sv/dsdt_sleep_type_scanner.sv
// top level of the dsdt s5 sleep type scanner
//
// feeds a dsdt table in one byte per beat, memory order, with i_start_req set
// on byte 0 (a byte with i_start_req clears the parse state but the last-byte
// position before it is taken; without any start after reset the first byte
// counts as byte 0). the block checks the "DSDT" signature, picks up the
// little-endian length from bytes 4..7, keeps an 8-bit checksum, and from
// offset 36 looks for the first _S5_ name object (0x08 or 0x08 '\' ahead of it,
// package op 0x12 after it). it skips the pkglength bytes and element count
// and captures two sleep types, each with an optional 0x0a byte prefix. exactly
// one result beat comes out per table: on byte 7 when the length is below 36,
// else on the last byte. status 0 ok, 1 bad signature/checksum/length, 2 no
// _S5_, 3 _S5_ malformed; the words are (type << 10 | bit 13) truncated to 16
// bits, zero unless ok. bytes after the result are swallowed until the next
// start. throughput is one byte per clock while the skid entry is free: all
// per-byte work sits between the parse state registers and a result register,
// and a one-entry skid behind it keeps bytes flowing while one result waits to
// be taken. the last byte's result is registered in the result or skid register.
module dsdt_sleep_type_scanner
    import sst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_start_req,
    input  logic [7:0]  i_data_byte,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_sleep_word_a,
    output logic [15:0] o_sleep_word_b
);

    logic    beat;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    can_push;

    // a byte is taken whenever the skid entry is free
    assign o_ready = can_push;
    assign beat    = i_valid && can_push;

    sst_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_start_req (i_start_req),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register plus skid
    sst_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_data     (res),
        .o_can_push (can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (out_res)
    );

    assign o_status       = out_res.status;
    assign o_sleep_word_a = out_res.word_a;
    assign o_sleep_word_b = out_res.word_b;

endmodule

### sv/sst_checker.sv
// port-level checker for the dsdt sleep type scanner and its bind
module sst_checker
    import sst_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [15:0] o_sleep_word_a,
    input logic [15:0] o_sleep_word_b
);

    // a stalled result beat stays up
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // words are zero on any failing status
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_sleep_word_a == 16'd0 && o_sleep_word_b == 16'd0)
        else $error("nonzero sleep word on failing status");

    // a good result always carries the enable bit
    a_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_sleep_word_a[13] && o_sleep_word_b[13])
        else $error("sleep word missing enable bit");

    // nothing pending right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a new result only follows an input byte beat
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready))
        else $error("result without a byte beat");

endmodule

bind dsdt_sleep_type_scanner sst_checker u_sst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_sleep_word_a (o_sleep_word_a),
    .o_sleep_word_b (o_sleep_word_b)
);
